// ----- design/spa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants and types of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int SLOTS  = 32;
  localparam int IDX_W  = $clog2(SLOTS + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] HEAD = IDX_W'(SLOTS);

  localparam int SIZE_W = 16;
  localparam logic [SIZE_W-1:0] SLOT_SIZE_RESET = 16'd64;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // command codes on the input channel
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;

  // status codes on the output channel
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  // operations after front-end classification
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_NEXT  = 3'd2;
  localparam logic [2:0] OP_BAD   = 3'd3;
  localparam logic [2:0] OP_BIG   = 3'd4;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
  } entry_t;

endpackage
`default_nettype wire

// ----- design/slot_pool_allocator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_pool_allocator_core
// Fixed pool of equal-sized slots with a LIFO free list and a circular
// doubly linked active list behind a head sentinel.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (cmd, slot_index, request_bytes) are taken when in_valid is
//   high and in_stall is low. cmd 0 allocates, 1 frees a slot, 2 returns the
//   active successor of a slot or of the head (index 32).
//   One result item (status, result_slot, at_end) follows per input item,
//   in order, taken when out_valid is high and out_stall is low.
//   slot_size is written through cfg_we / cfg_wdata while the block is idle.
//   An accepted item passes through the queue, then the back end's read
//   state, which reads the link memories, and its write state, which
//   rewrites them and registers the result before the next item is read.
//   A two-entry queue lets the front keep taking items while the back end
//   works; in_stall rises when it is full.
//   When out_stall holds a result, the back end waits with its next item
//   and the queue fills, then in_stall rises.
//   Reset (rst, synchronous) empties the active list, chains all slots on
//   the free list, clears the queue and sets slot_size to 64. No clearing
//   pass is needed; the block takes items right after reset.
// ----------------------------------------------------------------------------
module slot_pool_allocator_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [spa_pkg::SIZE_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 cmd,
  input  wire logic [spa_pkg::IDX_W-1:0]  slot_index,
  input  wire logic [spa_pkg::SIZE_W-1:0] request_bytes,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [spa_pkg::IDX_W-1:0]       result_slot,
  output logic                            at_end
);

  logic [spa_pkg::SIZE_W-1:0] slot_size;
  spa_pkg::entry_t            front_entry;
  spa_pkg::entry_t            q_entry;
  logic                       q_nonempty;
  logic                       q_full;
  logic                       q_pop;
  logic                       push;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_size <= spa_pkg::SLOT_SIZE_RESET;
    end else if (cfg_we) begin
      slot_size <= cfg_wdata;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  spa_front u_front (
    .cmd           (cmd),
    .slot_index    (slot_index),
    .request_bytes (request_bytes),
    .slot_size     (slot_size),
    .entry         (front_entry)
  );

  spa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head_entry (q_entry),
    .nonempty   (q_nonempty),
    .full       (q_full)
  );

  spa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_entry     (q_entry),
    .q_nonempty  (q_nonempty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .result_slot (result_slot),
    .at_end      (at_end)
  );

`ifndef SYNTHESIS
  a_reset_clears_out : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_end_is_head : assert property (@(posedge clk) disable iff (rst)
    (out_valid && at_end) |-> (result_slot == spa_pkg::HEAD && status == spa_pkg::ST_OK))
    else $error("end flag without head result");

  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != spa_pkg::ST_OK) |-> (result_slot == '0 && !at_end))
    else $error("error result carries a slot or end flag");

  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    (q_full && !q_pop) |=> q_full)
    else $error("queue lost an item while full");
`endif

endmodule
`default_nettype wire

// ----- design/spa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_front
// Decodes an incoming command and rejects oversized alloc requests.
// ----------------------------------------------------------------------------
module spa_front (
  input  wire logic [1:0]                  cmd,
  input  wire logic [spa_pkg::IDX_W-1:0]   slot_index,
  input  wire logic [spa_pkg::SIZE_W-1:0]  request_bytes,
  input  wire logic [spa_pkg::SIZE_W-1:0]  slot_size,
  output spa_pkg::entry_t                  entry
);

  always_comb begin
    entry.idx = slot_index;
    case (cmd)
      spa_pkg::CMD_ALLOC: begin
        // size is checked before fullness
        entry.op = (request_bytes > slot_size) ? spa_pkg::OP_BIG : spa_pkg::OP_ALLOC;
      end
      spa_pkg::CMD_FREE: entry.op = spa_pkg::OP_FREE;
      spa_pkg::CMD_NEXT: entry.op = spa_pkg::OP_NEXT;
      default:           entry.op = spa_pkg::OP_BAD;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/spa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module spa_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire spa_pkg::entry_t push_entry,
  input  wire logic            pop,
  output spa_pkg::entry_t      head_entry,
  output logic                 nonempty,
  output logic                 full
);

  spa_pkg::entry_t                 slots_q [spa_pkg::QDEPTH];
  logic [spa_pkg::QPTR_W-1:0]      wr_ptr;
  logic [spa_pkg::QPTR_W-1:0]      rd_ptr;
  logic [spa_pkg::QCNT_W-1:0]      count;

  assign nonempty   = (count != '0);
  assign full       = (count == spa_pkg::QCNT_W'(spa_pkg::QDEPTH));
  assign head_entry = slots_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_q[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == spa_pkg::QPTR_W'(spa_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == spa_pkg::QPTR_W'(spa_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/spa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_back
// Executes queued items against the free list and the active list.
// The read state reads the link memories, the write state rewrites them.
// ----------------------------------------------------------------------------
module spa_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire spa_pkg::entry_t            q_entry,
  input  wire logic                       q_nonempty,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [spa_pkg::IDX_W-1:0]       result_slot,
  output logic                            at_end
);

  localparam logic S_READ  = 1'b0;
  localparam logic S_WRITE = 1'b1;

  localparam int AW = spa_pkg::ADDR_W;
  localparam int IW = spa_pkg::IDX_W;

  // link memories; the head's links live in head_next / head_prev
  logic [IW-1:0] free_link   [spa_pkg::SLOTS];
  logic [IW-1:0] active_next [spa_pkg::SLOTS];
  logic [IW-1:0] active_prev [spa_pkg::SLOTS];

  logic [spa_pkg::SLOTS-1:0] fl_written;
  logic [spa_pkg::SLOTS-1:0] in_use;
  logic [IW-1:0]             free_top;
  logic [IW-1:0]             head_next;
  logic [IW-1:0]             head_prev;
  logic                      state;

  logic [2:0]    op_q;
  logic [IW-1:0] idx_q;
  logic          slot_ok_q;
  logic [IW-1:0] fl_rd;
  logic          fl_vld_rd;
  logic [IW-1:0] nx_rd;
  logic [IW-1:0] pv_rd;

  logic          out_free;
  logic          commit;
  logic          is_full;
  logic [IW-1:0] fl_val;
  logic [IW-1:0] succ;
  logic          do_alloc;
  logic          do_free;
  logic          do_next;
  logic          idx_is_head;

  logic          nx_we;
  logic [AW-1:0] nx_waddr;
  logic [IW-1:0] nx_wdata;
  logic          pv_we;
  logic [AW-1:0] pv_waddr;
  logic [IW-1:0] pv_wdata;

  assign q_pop    = (state == S_READ) && q_nonempty;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_WRITE) && out_free;

  assign idx_is_head = (idx_q == spa_pkg::HEAD);
  assign is_full     = (free_top >= spa_pkg::HEAD);
  // an unwritten free link still holds its reset chain value
  assign fl_val      = fl_vld_rd ? fl_rd : free_top + IW'(1);
  // the tail's successor is always the head, so its stored link is not kept
  assign succ        = idx_is_head ? head_next :
                       ((idx_q == head_prev) ? spa_pkg::HEAD : nx_rd);

  assign do_alloc = (op_q == spa_pkg::OP_ALLOC) && !is_full;
  assign do_free  = (op_q == spa_pkg::OP_FREE) && slot_ok_q;
  assign do_next  = (op_q == spa_pkg::OP_NEXT) && (idx_is_head || slot_ok_q);

  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = head_prev[AW-1:0];
    nx_wdata = free_top;
    pv_we    = 1'b0;
    pv_waddr = free_top[AW-1:0];
    pv_wdata = head_prev;
    if (commit && do_alloc) begin
      nx_we = (head_prev != spa_pkg::HEAD);
      pv_we = 1'b1;
    end else if (commit && do_free) begin
      nx_we    = (pv_rd != spa_pkg::HEAD);
      nx_waddr = pv_rd[AW-1:0];
      nx_wdata = succ;
      pv_we    = (succ != spa_pkg::HEAD);
      pv_waddr = succ[AW-1:0];
      pv_wdata = pv_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      active_next[nx_waddr] <= nx_wdata;
    end
    if (pv_we) begin
      active_prev[pv_waddr] <= pv_wdata;
    end
    if (commit && do_free) begin
      free_link[idx_q[AW-1:0]] <= free_top;
    end
    if (q_pop) begin
      fl_rd <= free_link[free_top[AW-1:0]];
      nx_rd <= active_next[q_entry.idx[AW-1:0]];
      pv_rd <= active_prev[q_entry.idx[AW-1:0]];
    end
  end

  // item fields and read-side flags
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_q      <= q_entry.op;
      idx_q     <= q_entry.idx;
      slot_ok_q <= (q_entry.idx < spa_pkg::HEAD) && in_use[q_entry.idx[AW-1:0]];
      fl_vld_rd <= fl_written[free_top[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_READ;
      fl_written <= '0;
      in_use     <= '0;
      free_top   <= '0;
      head_next  <= spa_pkg::HEAD;
      head_prev  <= spa_pkg::HEAD;
      out_valid  <= 1'b0;
    end else begin
      if (q_pop) begin
        state <= S_WRITE;
      end else if (commit) begin
        state <= S_READ;
      end

      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (commit && do_alloc) begin
        free_top                   <= fl_val;
        in_use[free_top[AW-1:0]]   <= 1'b1;
        head_prev                  <= free_top;
        if (head_prev == spa_pkg::HEAD) begin
          head_next <= free_top;
        end
      end else if (commit && do_free) begin
        in_use[idx_q[AW-1:0]]     <= 1'b0;
        fl_written[idx_q[AW-1:0]] <= 1'b1;
        free_top                  <= idx_q;
        if (pv_rd == spa_pkg::HEAD) begin
          head_next <= succ;
        end
        if (succ == spa_pkg::HEAD) begin
          head_prev <= pv_rd;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= spa_pkg::ST_BAD;
      result_slot <= '0;
      at_end      <= 1'b0;
      case (op_q)
        spa_pkg::OP_ALLOC: begin
          if (is_full) begin
            status <= spa_pkg::ST_FULL;
          end else begin
            status      <= spa_pkg::ST_OK;
            result_slot <= free_top;
          end
        end
        spa_pkg::OP_FREE: begin
          if (do_free) begin
            status      <= spa_pkg::ST_OK;
            result_slot <= pv_rd;
          end
        end
        spa_pkg::OP_NEXT: begin
          if (do_next) begin
            status      <= spa_pkg::ST_OK;
            result_slot <= succ;
            at_end      <= (succ == spa_pkg::HEAD);
          end
        end
        spa_pkg::OP_BIG: status <= spa_pkg::ST_TOO_LARGE;
        default:         status <= spa_pkg::ST_BAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- dv/slot_pool_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_core_test
// Self-checking bench for the slot pool allocator. A short scripted run
// covers the too-large and bad codes and list edges. Random phases then
// follow, each with its own slot size, filling and draining the pool. Every
// result is checked in order against its scripted value or a behavioral pool.
// ----------------------------------------------------------------------------
module slot_pool_allocator_core_test;
  import spa_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int MAX_WAIT       = 18;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_AT_RESULT = 600;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 170;
  localparam int NUM_PHASES     = 8;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic             last;
  } outcome_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] nbytes;
    logic              typed;
    outcome_t          want;
  } script_row_t;

  localparam int SCRIPT_LEN = 22;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_NEXT,   HEAD,  16'd0,     1'b1, '{ST_OK,        HEAD,  1'b1}},
    '{CMD_ALLOC,  6'd0,  16'd65,    1'b1, '{ST_TOO_LARGE, 6'd0,  1'b0}},
    '{CMD_ALLOC,  6'd0,  16'd64,    1'b1, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_ALLOC,  6'd31, 16'd0,     1'b1, '{ST_OK,        6'd1,  1'b0}},
    '{CMD_ALLOC,  6'd0,  16'd17,    1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_NEXT,   HEAD,  16'hFFFF,  1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_NEXT,   6'd0,  16'd0,     1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_NEXT,   6'd2,  16'd0,     1'b1, '{ST_OK,        HEAD,  1'b1}},
    '{CMD_FREE,   HEAD,  16'd0,     1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_FREE,   6'd5,  16'd0,     1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_FREE,   6'h3F, 16'hFFFF,  1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_NEXT,   6'h3F, 16'd0,     1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_NEXT,   6'd33, 16'd0,     1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_NEXT,   6'd7,  16'd0,     1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_UNUSED, 6'h3F, 16'hFFFF,  1'b1, '{ST_BAD,       6'd0,  1'b0}},
    '{CMD_FREE,   6'd1,  16'd0,     1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_FREE,   6'd0,  16'd0,     1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_ALLOC,  6'd0,  16'd64,    1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_ALLOC,  6'd0,  16'hFFFF,  1'b1, '{ST_TOO_LARGE, 6'd0,  1'b0}},
    '{CMD_FREE,   6'd2,  16'd0,     1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_FREE,   6'd0,  16'd0,     1'b0, '{ST_OK,        6'd0,  1'b0}},
    '{CMD_NEXT,   HEAD,  16'd0,     1'b0, '{ST_OK,        6'd0,  1'b0}}
  };

  // zero means draw a random size for that phase
  localparam logic [SIZE_W-1:0] PHASE_SIZE [NUM_PHASES] = '{
    16'd64, 16'd1, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd300
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        cmd;
  logic [IDX_W-1:0]  slot_index;
  logic [SIZE_W-1:0] request_bytes;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        status;
  logic [IDX_W-1:0]  result_slot;
  logic              at_end;

  slot_pool_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .slot_index    (slot_index),
    .request_bytes (request_bytes),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .result_slot   (result_slot),
    .at_end        (at_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the pool: links, free stack, ownership and slot size
  logic [IDX_W-1:0]  fwd_link   [SLOTS+1];
  logic [IDX_W-1:0]  back_link  [SLOTS+1];
  logic [IDX_W-1:0]  spare_link [SLOTS+1];
  logic [IDX_W-1:0]  spare_top;
  bit                taken      [SLOTS+1];
  logic [SIZE_W-1:0] slot_bytes;

  outcome_t         pending_results [$];
  outcome_t         oldest_result;
  int               mismatch_count = 0;
  int               results_taken  = 0;
  bit               send_quiet     = 1'b0;
  bit               sink_quiet     = 1'b0;
  bit               held_off       = 1'b0;
  logic [IDX_W-1:0] walk_cursor    = HEAD;

  task automatic pool_reset();
    for (int i = 0; i <= SLOTS; i++) begin
      spare_link[i] = IDX_W'(i + 1);
      taken[i]      = 1'b0;
      fwd_link[i]   = '0;
      back_link[i]  = '0;
    end
    spare_top       = '0;
    fwd_link[HEAD]  = HEAD;
    back_link[HEAD] = HEAD;
    slot_bytes      = SLOT_SIZE_RESET;
  endtask

  function automatic outcome_t pool_apply(input logic [1:0] op, input logic [IDX_W-1:0] ix,
                                          input logic [SIZE_W-1:0] nb);
    outcome_t         r;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    r = '{ST_BAD, '0, 1'b0};
    case (op)
      CMD_ALLOC: begin
        // size is checked ahead of fullness
        if (nb > slot_bytes) begin
          r.status = ST_TOO_LARGE;
        end else if (spare_top >= HEAD) begin
          r.status = ST_FULL;
        end else begin
          s               = spare_top;
          spare_top       = spare_link[s];
          taken[s]        = 1'b1;
          tail            = back_link[HEAD];
          fwd_link[tail]  = s;
          back_link[s]    = tail;
          fwd_link[s]     = HEAD;
          back_link[HEAD] = s;
          r = '{ST_OK, s, 1'b0};
        end
      end
      CMD_FREE: begin
        if (ix < HEAD && taken[ix]) begin
          p             = back_link[ix];
          n             = fwd_link[ix];
          fwd_link[p]   = n;
          back_link[n]  = p;
          taken[ix]     = 1'b0;
          spare_link[ix] = spare_top;
          spare_top     = ix;
          r = '{ST_OK, p, 1'b0};
        end
      end
      CMD_NEXT: begin
        if (ix == HEAD || (ix < HEAD && taken[ix])) begin
          n = fwd_link[ix];
          r = '{ST_OK, n, n == HEAD};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // present one item after a random gap and record what it must produce
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] ix,
                           input logic [SIZE_W-1:0] nb, input logic typed,
                           input outcome_t typed_want, output outcome_t got);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    cmd           = op;
    slot_index    = ix;
    request_bytes = nb;
    do @(posedge clk); while (in_stall);
    got = pool_apply(op, ix, nb);
    pending_results.push_back(typed ? typed_want : got);
    @(negedge clk);
  endtask

  // mostly well-formed traffic built from the current pool contents
  task automatic random_item(input int alloc_pct);
    logic [1:0]        op;
    logic [IDX_W-1:0]  ix;
    logic [SIZE_W-1:0] nb;
    logic [IDX_W-1:0]  in_pool [$];
    outcome_t          got;
    int                pick;
    op   = CMD_NEXT;
    ix   = IDX_W'($urandom_range(0, 63));
    nb   = SIZE_W'($urandom);
    for (int i = 0; i < SLOTS; i++)
      if (taken[i]) in_pool.push_back(IDX_W'(i));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op = 2'($urandom_range(0, 3));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        op   = CMD_ALLOC;
        pick = $urandom_range(0, 19);
        if (pick == 0) nb = slot_bytes;
        else if (pick == 1) nb = '0;
        else if (pick == 3 && slot_bytes != '1) nb = slot_bytes + 1'b1;
        else if (pick != 2) nb = SIZE_W'($urandom_range(0, slot_bytes));
      end else if (pick < alloc_pct + (100 - alloc_pct) / 2) begin
        op = CMD_FREE;
        if (in_pool.size() == 0) ix = IDX_W'($urandom_range(0, 63));
        else if (taken[walk_cursor] && $urandom_range(0, 1) == 1) ix = walk_cursor;
        else ix = in_pool[$urandom_range(0, in_pool.size() - 1)];
      end else begin
        op   = CMD_NEXT;
        pick = $urandom_range(0, 3);
        if (pick < 2 && (walk_cursor == HEAD || taken[walk_cursor])) ix = walk_cursor;
        else if (pick == 2 || in_pool.size() == 0) ix = HEAD;
        else ix = in_pool[$urandom_range(0, in_pool.size() - 1)];
      end
    end
    send_item(op, ix, nb, 1'b0, '0, got);
    // follow the iterator; removal steps it back to the predecessor
    if (got.status == ST_OK && (op == CMD_NEXT || (op == CMD_FREE && ix == walk_cursor)))
      walk_cursor = got.slot;
  endtask

  task automatic settle_pool();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_slot_size(input logic [SIZE_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    slot_bytes = value;
  endtask

  initial begin : stimulus
    outcome_t          got;
    logic [SIZE_W-1:0] size_now;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    cmd           = CMD_ALLOC;
    slot_index    = '0;
    request_bytes = '0;
    pool_reset();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < SCRIPT_LEN; r++)
      send_item(SCRIPT[r].op, SCRIPT[r].idx, SCRIPT[r].nbytes, SCRIPT[r].typed,
                SCRIPT[r].want, got);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_pool();
      size_now = PHASE_SIZE[p];
      if (size_now == '0) size_now = SIZE_W'($urandom_range(1, 65535));
      write_slot_size(size_now);
      // fill toward full in the first half, drain in the second
      for (int k = 0; k < PHASE_ITEMS; k++)
        random_item(k < PHASE_ITEMS / 2 ? 65 : 20);
    end

    settle_pool();
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_sink
    int wait_cycles;
    out_stall = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      // one long hold-off so the queue fills and the input stalls
      if (!held_off && results_taken >= HOLD_AT_RESULT) begin
        held_off  = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
      wait_cycles = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_taken++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status=%0d slot=%0d end=%0b",
                                  status, result_slot, at_end));
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status)
          report_mismatch($sformatf("status %0d, want %0d", status, oldest_result.status));
        if (result_slot !== oldest_result.slot)
          report_mismatch($sformatf("result_slot %0d, want %0d", result_slot,
                                    oldest_result.slot));
        if (at_end !== oldest_result.last)
          report_mismatch($sformatf("at_end %0b, want %0b", at_end, oldest_result.last));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
